// ----- hdl/spd_pkg.sv -----
// Shared types, character constants and the hex digit decode for the percent decoder.
`default_nettype none
package spd_pkg;

	localparam logic [7:0] CH_PERCENT = 8'h25;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_F = 8'h66;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_F = 8'h46;
	localparam logic [3:0] HEX_TEN    = 4'd10;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADHEX = 2'd1,
		ST_ZERO   = 2'd2,
		ST_TRUNC  = 2'd3
	} status_t;

	typedef struct packed {
		logic [7:0] in_char;
		logic       last_char;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       byte_valid;
		status_t    status;
		logic       end_of_string;
	} result_t;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	// Value of an ASCII hex digit in either case; ok is low for anything else.
	function automatic hex_digit_t hex_decode(input logic [7:0] ch);
		hex_digit_t d;
		d.ok    = 1'b0;
		d.value = 4'd0;
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			d.ok    = 1'b1;
			d.value = 4'(ch - CH_ZERO);
		end else if (ch >= CH_LOWER_A && ch <= CH_LOWER_F) begin
			d.ok    = 1'b1;
			d.value = 4'(ch - CH_LOWER_A) + HEX_TEN;
		end else if (ch >= CH_UPPER_A && ch <= CH_UPPER_F) begin
			d.ok    = 1'b1;
			d.value = 4'(ch - CH_UPPER_A) + HEX_TEN;
		end
		return d;
	endfunction

endpackage
`default_nettype wire

// ----- hdl/spd_if.sv -----
// Valid/ready stream interfaces for the character input and the decoded result output.
`default_nettype none
interface spd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_char;
	logic       last_char;

	modport source (output valid, output in_char, output last_char, input ready);
	modport sink   (input valid, input in_char, input last_char, output ready);
endinterface

interface spd_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       byte_valid;
	logic [1:0] status;
	logic       end_of_string;

	modport source (output valid, output out_byte, output byte_valid, output status,
		output end_of_string, input ready);
	modport sink   (input valid, input out_byte, input byte_valid, input status,
		input end_of_string, output ready);
endinterface
`default_nettype wire

// ----- hdl/spd_core.sv -----
// Escape phase machine: decoder state registers and the per-character step logic.
`default_nettype none
module spd_core import spd_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_item_t item,
	output result_t       res
);

	phase_t     phase_q, phase_d;
	logic [3:0] nibble_q, nibble_d;
	status_t    err_q, err_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			nibble_q <= 4'd0;
			err_q    <= ST_OK;
		end else if (step) begin
			phase_q  <= phase_d;
			nibble_q <= nibble_d;
			err_q    <= err_d;
		end
	end

	always_comb begin
		hex_digit_t d;
		status_t    err_n;
		logic [7:0] v;
		d              = hex_decode(item.in_char);
		v              = {nibble_q, d.value};
		err_n          = err_q;
		phase_d        = PH_IDLE;
		nibble_d       = nibble_q;
		res.out_byte   = 8'd0;
		res.byte_valid = 1'b0;
		case (phase_q)
			PH_HIGH: begin
				// A cut-short escape outranks a bad high digit on the last character.
				if (err_q == ST_OK) begin
					if (item.last_char) begin
						err_n = ST_TRUNC;
					end else if (!d.ok) begin
						err_n = ST_BADHEX;
					end
				end
				nibble_d = d.value;
				phase_d  = PH_LOW;
			end
			PH_LOW: begin
				if (!d.ok) begin
					if (err_q == ST_OK) err_n = ST_BADHEX;
				end else if (v == 8'd0) begin
					if (err_q == ST_OK) err_n = ST_ZERO;
				end else if (err_q == ST_OK) begin
					res.out_byte   = v;
					res.byte_valid = 1'b1;
				end
				phase_d = PH_IDLE;
			end
			default: begin
				if (item.in_char == CH_PERCENT) begin
					if (item.last_char && err_q == ST_OK) err_n = ST_TRUNC;
					phase_d = PH_HIGH;
				end else if (err_q == ST_OK) begin
					res.out_byte   = item.in_char;
					res.byte_valid = 1'b1;
				end
			end
		endcase
		res.status        = err_n;
		res.end_of_string = item.last_char;
		err_d             = err_n;
		// The end of a string puts everything back to idle.
		if (item.last_char) begin
			phase_d  = PH_IDLE;
			nibble_d = 4'd0;
			err_d    = ST_OK;
		end
	end

endmodule
`default_nettype wire

// ----- hdl/strict_percent_decoder_top.sv -----
// Top level of the strict percent decoder: input register, phase machine, result register.
//
//  Channel | Interface  | Direction | Payload
//  chars   | spd_in_if  | in        | in_char[7:0], last_char
//  bytes   | spd_out_if | out       | out_byte[7:0], byte_valid, status[1:0], end_of_string
//
// One character is taken per cycle unless the output stalls; each result is registered.
// Each character gives exactly one result transaction.
// Reset (arst_n low) returns the escape phase, held nibble and sticky error to idle.
// A stalled output holds its result; the input register keeps accepting until both
// the input and result registers are full.
`default_nettype none
module strict_percent_decoder_top import spd_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	spd_in_if.sink    chars,
	spd_out_if.source bytes
);

	logic     valid_s1;
	in_item_t item_s1;
	logic     valid_s2;
	result_t  res_s2;
	result_t  res;
	logic     adv;

	assign adv         = valid_s1 && (!valid_s2 || bytes.ready);
	assign chars.ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (chars.valid && chars.ready) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= 1'b1;
			end else if (bytes.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			item_s1.in_char   <= chars.in_char;
			item_s1.last_char <= chars.last_char;
		end
		if (adv) begin
			res_s2 <= res;
		end
	end

	spd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (adv),
		.item   (item_s1),
		.res    (res)
	);

	assign bytes.valid         = valid_s2;
	assign bytes.out_byte      = res_s2.out_byte;
	assign bytes.byte_valid    = res_s2.byte_valid;
	assign bytes.status        = res_s2.status;
	assign bytes.end_of_string = res_s2.end_of_string;

endmodule
`default_nettype wire

// ----- hdl/spd_checker.sv -----
// Port-level checker for the percent decoder and its bind to the top level.
`default_nettype none
module spd_checker import spd_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [7:0] out_byte,
	input wire logic       byte_valid,
	input wire logic [1:0] status,
	input wire logic       end_of_string
);

	logic       out_acc;
	logic       open_q;
	logic [1:0] last_status_q;

	assign out_acc = out_valid && out_ready;

	// Tracks the status of the previous transaction within the current string.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q        <= 1'b0;
			last_status_q <= ST_OK;
		end else if (out_acc) begin
			open_q        <= !end_of_string;
			last_status_q <= status;
		end
	end

	a_byte_only_when_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && byte_valid |-> status == ST_OK)
		else $error("decoded byte shown with a nonzero status");

	a_no_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !byte_valid |-> out_byte == 8'd0)
		else $error("out_byte nonzero without byte_valid");

	a_error_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && open_q && last_status_q != ST_OK |-> status == last_status_q)
		else $error("error status changed before the end of the string");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(status)
			&& $stable(byte_valid) && $stable(end_of_string))
		else $error("result changed while stalled");

endmodule

bind strict_percent_decoder_top spd_checker u_spd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.out_valid     (bytes.valid),
	.out_ready     (bytes.ready),
	.out_byte      (bytes.out_byte),
	.byte_valid    (bytes.byte_valid),
	.status        (bytes.status),
	.end_of_string (bytes.end_of_string)
);
`default_nettype wire
